// ----- hdl/sddq_pkg.sv -----
package sddq_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 16;
  localparam int unsigned IdxW   = 3;

  localparam logic [IdxW-1:0] RegInvertInput    = 3'd0;
  localparam logic [IdxW-1:0] RegActivateDelay  = 3'd1;
  localparam logic [IdxW-1:0] RegDeactivateDelay = 3'd2;
  localparam logic [IdxW-1:0] RegStartDelay     = 3'd3;
  localparam logic [IdxW-1:0] RegCooldownTicks  = 3'd4;

  localparam logic [DelayW-1:0] CooldownReset = 16'd50;

  typedef struct packed {
    logic              invert_input;
    logic [DelayW-1:0] activate_delay;
    logic [DelayW-1:0] deactivate_delay;
    logic [DelayW-1:0] start_delay;
    logic [DelayW-1:0] cooldown_ticks;
  } cfg_t;

  typedef struct packed {
    logic changed;
    logic active;
  } result_t;

endpackage

// ----- hdl/sensor_debounce_delay_qualifier.sv -----
// Debounce and delay qualifier for one sensor input. Each item carries the
// current tick count and the raw pin level; every item yields exactly one
// result with a change flag and the qualified active state. The compare and
// deadline add sit between the input port and a single output register, so a
// result is offered in the cycle after its item is accepted, and a new item is
// taken every cycle while the consumer keeps up. The
// cooldown, the activate and deactivate delays and the start-up hold are
// measured in the caller's ticks, not in clock cycles.
module sensor_debounce_delay_qualifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // now[31:0], pin_level, zero padding
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // changed, active, zero padding
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sddq_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [15:0]                cfg_data_i
);
  import sddq_pkg::*;

  cfg_t    cfg_q;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;
  logic    accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert_input     <= 1'b0;
      cfg_q.activate_delay   <= '0;
      cfg_q.deactivate_delay <= '0;
      cfg_q.start_delay      <= '0;
      cfg_q.cooldown_ticks   <= CooldownReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegInvertInput:     cfg_q.invert_input     <= cfg_data_i[0];
        RegActivateDelay:   cfg_q.activate_delay   <= cfg_data_i;
        RegDeactivateDelay: cfg_q.deactivate_delay <= cfg_data_i;
        RegStartDelay:      cfg_q.start_delay      <= cfg_data_i;
        RegCooldownTicks:   cfg_q.cooldown_ticks   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sddq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .now_i       (s_axis_tdata[TimeW-1:0]),
    .pin_level_i (s_axis_tdata[TimeW]),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, res_q.active, res_q.changed};

endmodule

// ----- hdl/sddq_core.sv -----
module sddq_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sddq_pkg::cfg_t              cfg_i,
  input  logic                        accept_i,
  input  logic [sddq_pkg::TimeW-1:0]  now_i,
  input  logic                        pin_level_i,
  output sddq_pkg::result_t           result_o
);
  import sddq_pkg::*;

  logic             active_q, active_d;
  logic             cool_q, cool_d;
  logic             delay_q, delay_d;
  logic             startup_q, startup_d;
  logic [TimeW-1:0] deadline_q, deadline_d;

  logic             hold_on;
  logic             was_delay;
  logic             level;
  logic [DelayW-1:0] wait_ticks;

  always_comb begin
    active_d   = active_q;
    cool_d     = cool_q;
    delay_d    = delay_q;
    startup_d  = startup_q;
    deadline_d = deadline_q;
    was_delay  = delay_q;
    level      = pin_level_i ^ cfg_i.invert_input;
    wait_ticks = active_q ? cfg_i.deactivate_delay : cfg_i.activate_delay;
    hold_on    = startup_q && (cfg_i.start_delay != '0);
    result_o.changed = 1'b0;

    if (startup_q && !hold_on) begin
      startup_d = 1'b0;
    end

    if (hold_on && (now_i < {{(TimeW-DelayW){1'b0}}, cfg_i.start_delay})) begin
      // Start-up hold still running: the item is ignored.
    end else if (!hold_on && (cool_q || delay_q) && (now_i < deadline_q)) begin
      // Waiting for the pending deadline.
    end else begin
      if (hold_on) begin
        startup_d = 1'b0;
        was_delay = 1'b1;
      end
      cool_d  = 1'b0;
      delay_d = 1'b0;
      if (level != active_q) begin
        if (!cool_q && !was_delay) begin
          cool_d     = 1'b1;
          deadline_d = now_i + {{(TimeW-DelayW){1'b0}}, cfg_i.cooldown_ticks};
        end else if (cool_q && (wait_ticks != '0)) begin
          delay_d    = 1'b1;
          deadline_d = now_i + {{(TimeW-DelayW){1'b0}}, wait_ticks};
        end else begin
          active_d         = ~active_q;
          result_o.changed = 1'b1;
        end
      end
    end
    result_o.active = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      cool_q     <= 1'b0;
      delay_q    <= 1'b0;
      startup_q  <= 1'b1;
      deadline_q <= '0;
    end else if (accept_i) begin
      active_q   <= active_d;
      cool_q     <= cool_d;
      delay_q    <= delay_d;
      startup_q  <= startup_d;
      deadline_q <= deadline_d;
    end
  end

endmodule

// ----- hdl/sddq_checker.sv -----
module sddq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  default disable iff (!rst_ni);

  a_out_hold: assert property (@(posedge clk_i)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("Result item changed while stalled.");

  a_ready: assert property (@(posedge clk_i)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("Input stalled without a waiting result item.");

  a_one_result: assert property (@(posedge clk_i)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("Accepted item gave no result item.");

endmodule

bind sensor_debounce_delay_qualifier sddq_checker u_sddq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/sensor_debounce_delay_qualifier_test.sv -----
`timescale 1ns / 1ps

module sensor_debounce_delay_qualifier_test;
  import sddq_pkg::*;

  localparam int StallLimit = 1000;
  localparam int RandomItems = 650;
  localparam int PlanRows = 29;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [IdxW-1:0]   idx;
    logic [TimeW-1:0]  value;
    logic              pin;
    bit                typed;
    result_t           res;
  } plan_row_t;

  typedef struct {
    bit      given;
    result_t res;
  } typed_entry_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata = '0;  // now[31:0], pin_level, zero padding
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;       // changed, active, zero padding
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IdxW-1:0]   cfg_index_i = '0;
  logic [15:0]       cfg_data_i = '0;

  sensor_debounce_delay_qualifier dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  cfg_t             regs = '{invert_input: 1'b0, activate_delay: '0, deactivate_delay: '0,
                             start_delay: '0, cooldown_ticks: CooldownReset};
  logic             q_active = 1'b0;
  logic             q_cool = 1'b0;
  logic             q_delay = 1'b0;
  logic             q_hold = 1'b1;
  logic [TimeW-1:0] q_deadline = '0;

  result_t          pending_results[$];
  typed_entry_t     typed_results[$];
  int               mismatches = 0;
  int               stall_cycles = 0;
  bit               idle_on = 1'b1;
  int               ready_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic result_t qualify(input logic [TimeW-1:0] now, input logic pin);
    logic              was_cool;
    logic              was_delay;
    logic              go;
    logic              toggled;
    logic [DelayW-1:0] dly;
    result_t           r;
    was_cool = q_cool;
    was_delay = q_delay;
    go = 1'b1;
    toggled = 1'b0;
    if (q_hold && regs.start_delay == 0) q_hold = 1'b0;
    if (q_hold) begin
      if (now < TimeW'(regs.start_delay)) begin
        go = 1'b0;
      end else begin
        q_hold = 1'b0;
        was_delay = 1'b1;
      end
    end else if ((was_cool || was_delay) && now < q_deadline) begin
      go = 1'b0;
    end
    if (go) begin
      q_cool = 1'b0;
      q_delay = 1'b0;
      if ((pin ^ regs.invert_input) != q_active) begin
        dly = q_active ? regs.deactivate_delay : regs.activate_delay;
        if (!was_cool && !was_delay) begin
          q_cool = 1'b1;
          q_deadline = now + TimeW'(regs.cooldown_ticks);
        end else if (was_cool && dly != 0) begin
          q_delay = 1'b1;
          q_deadline = now + TimeW'(dly);
        end else begin
          q_active = !q_active;
          toggled = 1'b1;
        end
      end
    end
    r.changed = toggled;
    r.active = q_active;
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t      got;
    result_t      want;
    typed_entry_t entry;
    bit           hit;
    hit = 1'b0;
    if (s_axis_tvalid && s_axis_tready) begin
      hit = 1'b1;
      want = qualify(s_axis_tdata[31:0], s_axis_tdata[32]);
      entry = typed_results.pop_front();
      if (entry.given) want = entry.res;
      pending_results.push_back(want);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      hit = 1'b1;
      got.changed = m_axis_tdata[0];
      got.active = m_axis_tdata[1];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result changed=%0b active=%0b", $time,
                   got.changed, got.active);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected changed=%0b active=%0b, got changed=%0b active=%0b",
                     $time, want.changed, want.active, got.changed, got.active);
        end
      end
    end
    if (cfg_valid_i && cfg_ready_o) begin
      hit = 1'b1;
      case (cfg_index_i)
        RegInvertInput:     regs.invert_input = cfg_data_i[0];
        RegActivateDelay:   regs.activate_delay = cfg_data_i;
        RegDeactivateDelay: regs.deactivate_delay = cfg_data_i;
        RegStartDelay:      regs.start_delay = cfg_data_i;
        RegCooldownTicks:   regs.cooldown_ticks = cfg_data_i;
        default: ;
      endcase
    end
    stall_cycles <= hit ? 0 : stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (ready_hold != 0) begin
        m_axis_tready <= 1'b0;
        ready_hold--;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 38);
      end
    end
  end

  task automatic put_item(input logic [TimeW-1:0] now, input logic pin, input bit typed,
                          input result_t res);
    typed_entry_t entry;
    entry.given = typed;
    entry.res = res;
    typed_results.push_back(entry);
    while (idle_on && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, pin, now};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 || typed_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    plan_row_t         plan [PlanRows];
    int                sent;
    int                phase;
    int                n;
    int                run;
    int                r;
    bit                extreme;
    logic [TimeW-1:0]  t;
    logic              lvl;
    logic [DelayW-1:0] dly;

    plan = '{
      '{RowCfg,  RegStartDelay,      32'd200,        1'b0, 1'b0, 2'b00},
      '{RowCfg,  RegCooldownTicks,   32'd5,          1'b0, 1'b0, 2'b00},
      '{RowCfg,  RegActivateDelay,   32'd10,         1'b0, 1'b0, 2'b00},
      '{RowCfg,  RegDeactivateDelay, 32'd0,          1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd0,          1'b1, 1'b1, 2'b00},
      '{RowItem, RegInvertInput,     32'd199,        1'b1, 1'b1, 2'b00},
      '{RowCfg,  RegStartDelay,      32'd100,        1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd150,        1'b1, 1'b1, 2'b11},
      '{RowItem, RegInvertInput,     32'd151,        1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd155,        1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd156,        1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd157,        1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd162,        1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd171,        1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd172,        1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd173,        1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd178,        1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd188,        1'b1, 1'b0, 2'b00},
      '{RowCfg,  RegInvertInput,     32'd1,          1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd189,        1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd194,        1'b1, 1'b0, 2'b00},
      '{RowCfg,  RegInvertInput,     32'd0,          1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'hFFFF_FFFE,  1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'hFFFF_FFFF,  1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd0,          1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd9,          1'b1, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'hFFFF_FFFF,  1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd4,          1'b0, 1'b0, 2'b00},
      '{RowItem, RegInvertInput,     32'd5,          1'b1, 1'b0, 2'b00}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].value[15:0]);
      end else begin
        put_item(plan[i].value, plan[i].pin, plan[i].typed, plan[i].res);
      end
    end

    sent = 0;
    phase = 0;
    lvl = 1'b0;
    while (sent < RandomItems) begin
      phase++;
      settle();
      extreme = (phase % 5 == 2);
      idle_on = (phase != 4);
      write_reg(RegInvertInput, 16'($urandom_range(0, 1)));
      dly = extreme ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                    : 16'($urandom_range(0, 12));
      write_reg(RegCooldownTicks, dly);
      dly = extreme ? 16'hFFFF : ($urandom_range(0, 2) == 0 ? 16'd0
                                                           : 16'($urandom_range(1, 15)));
      write_reg(RegActivateDelay, dly);
      dly = extreme ? 16'h0000 : ($urandom_range(0, 2) == 0 ? 16'd0
                                                           : 16'($urandom_range(1, 15)));
      write_reg(RegDeactivateDelay, dly);
      write_reg(RegStartDelay, extreme ? 16'hFFFF : 16'($urandom));
      if (phase == 6) ready_hold = 60;

      n = $urandom_range(30, 70);
      t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300) : $urandom;
      run = 0;
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) t = $urandom;
        else if (r < 10) t = t + $urandom_range(0, 70000);
        else t = t + $urandom_range(0, 4);
        if (run == 0) begin
          lvl = !lvl;
          run = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
        end
        run--;
        put_item(t, lvl ^ ($urandom_range(0, 19) == 0), 1'b0, 2'b00);
        sent++;
      end
    end

    settle();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
